[hw/rtl/ovnh_pkg.sv]
// ============================================================================
// ovnh_pkg
// Shared types, constants and the cosine weight function for the octave
// value noise height block.
// ============================================================================
package ovnh_pkg;

    // Configuration register indexes
    typedef enum logic [2:0] {
        REG_SEED     = 3'd0,
        REG_GAIN     = 3'd1,
        REG_OFFSET   = 3'd2,
        REG_OCTAVES  = 3'd3,
        REG_ROUGH    = 3'd4,
        REG_INV_SMTH = 3'd5
    } reg_index_t;

    // Controller states
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SETUP,
        ST_MIX,
        ST_SQ,
        ST_POLY,
        ST_FIN,
        ST_B1,
        ST_B2,
        ST_B3,
        ST_ACC,
        ST_SCALE,
        ST_BIAS,
        ST_HOLD
    } state_t;

    // Datapath operations
    typedef enum logic [3:0] {
        OP_NONE,
        OP_LOAD,
        OP_SETUP,
        OP_MIX,
        OP_SQ,
        OP_POLY,
        OP_FIN,
        OP_BLEND1,
        OP_BLEND2,
        OP_BLEND3,
        OP_ACCUM,
        OP_SCALE,
        OP_BIAS,
        OP_OUT
    } op_t;

    typedef struct packed {
        op_t        op;
        logic [1:0] corner;
    } dp_cmd_t;

    // Reset values of the configuration registers
    localparam logic [31:0] SEED_RST     = 32'd0;
    localparam logic [9:0]  GAIN_RST     = 10'd70;
    localparam logic [10:0] OFFSET_RST   = 11'd1;
    localparam logic [3:0]  OCTAVES_RST  = 4'd6;
    localparam logic [15:0] ROUGH_RST    = 16'd34734;
    localparam logic [23:0] INV_SMTH_RST = 24'd71392;

    // Hash and scaling constants
    localparam logic [31:0] HASH_MUL_A  = 32'd60493;
    localparam logic [31:0] HASH_ADD_B  = 32'd19990303;
    localparam logic [31:0] HASH_ADD_C  = 32'd1376312589;
    localparam logic [63:0] ANGLE_Q28   = 64'd842887331;
    localparam logic [14:0] INV_2P1_Q16 = 15'd31208;
    localparam logic [16:0] BIAS_Q16    = 17'd78643;
    localparam logic [16:0] NOISE_ONE   = 17'd65536;

    // Taylor divisors (2k-1)*2k for k = 1..15
    localparam logic [9:0] TAYLOR_DIV [15] = '{
        10'd2, 10'd12, 10'd30, 10'd56, 10'd90, 10'd132, 10'd182, 10'd240,
        10'd306, 10'd380, 10'd462, 10'd552, 10'd650, 10'd756, 10'd870
    };

    // Weight (1 - cos(theta))/2 in Q16 from a Q28 angle, Taylor series
    function automatic logic [16:0] cos_weight(input logic [63:0] theta);
        logic [63:0]        th2;
        logic [63:0]        term;
        logic signed [63:0] c;
        logic signed [63:0] w;
        th2  = (theta * theta) >> 28;
        term = 64'd1 << 28;
        c    = signed'(term);
        for (int k = 0; k < 15; k++)
        begin
            term = ((term * th2) >> 28) / TAYLOR_DIV[k];
            if (k[0] == 1'b0)
                c = c - signed'(term);
            else
                c = c + signed'(term);
        end
        w = (64'sd1 <<< 28) - c;
        if (w < 0)
            w = 0;
        w = (w + 64'sd4096) >>> 13;
        if (w > 64'sd65536)
            w = 64'sd65536;
        return w[16:0];
    endfunction

endpackage

[hw/rtl/ovnh_ctrl.sv]
// ============================================================================
// ovnh_ctrl
// Sequencer: walks octaves and corners, issues datapath commands and owns
// the input and output handshakes.
// ============================================================================
module ovnh_ctrl
    import ovnh_pkg::*;
#(
    parameter int MAX_OCTAVES = 8
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_stall,
    output logic       out_valid,
    input  logic       out_stall,
    input  logic [3:0] octave_count,
    output dp_cmd_t    cmd
);

    localparam int OW = $clog2(MAX_OCTAVES);

    state_t        state_reg, state_next;
    logic [OW-1:0] oct_reg, oct_next;
    logic [1:0]    corner_reg, corner_next;
    logic          out_valid_reg, out_valid_next;
    logic [4:0]    cnt;
    logic [5:0]    oct_plus2;
    logic          accept;

    // Clamp the octave setting
    assign cnt = ({1'b0, octave_count} > 5'(MAX_OCTAVES)) ? 5'(MAX_OCTAVES)
                                                          : {1'b0, octave_count};
    assign oct_plus2 = 6'(oct_reg) + 6'd2;
    assign accept    = in_valid && (state_reg == ST_IDLE);

    // Next state
    always_comb
    begin
        state_next  = state_reg;
        oct_next    = oct_reg;
        corner_next = corner_reg;
        case (state_reg)
            ST_IDLE:
            begin
                oct_next    = '0;
                corner_next = '0;
                if (in_valid)
                    state_next = (cnt > 5'd1) ? ST_SETUP : ST_SCALE;
            end
            ST_SETUP: state_next = ST_MIX;
            ST_MIX:   state_next = ST_SQ;
            ST_SQ:    state_next = ST_POLY;
            ST_POLY:  state_next = ST_FIN;
            ST_FIN:
            begin
                corner_next = corner_reg + 2'd1;
                state_next  = (corner_reg == 2'd3) ? ST_B1 : ST_MIX;
            end
            ST_B1:    state_next = ST_B2;
            ST_B2:    state_next = ST_B3;
            ST_B3:    state_next = ST_ACC;
            ST_ACC:
            begin
                if (oct_plus2 < {1'b0, cnt})
                begin
                    oct_next   = oct_reg + 1'b1;
                    state_next = ST_SETUP;
                end
                else
                    state_next = ST_SCALE;
            end
            ST_SCALE: state_next = ST_BIAS;
            ST_BIAS:  state_next = ST_HOLD;
            ST_HOLD:
            begin
                if (!out_valid_reg || !out_stall)
                    state_next = ST_IDLE;
            end
            default:  state_next = ST_IDLE;
        endcase
    end

    // Outputs and commands
    always_comb
    begin
        cmd.op         = OP_NONE;
        cmd.corner     = corner_reg;
        out_valid_next = out_valid_reg && out_stall;
        case (state_reg)
            ST_IDLE:  cmd.op = accept ? OP_LOAD : OP_NONE;
            ST_SETUP: cmd.op = OP_SETUP;
            ST_MIX:   cmd.op = OP_MIX;
            ST_SQ:    cmd.op = OP_SQ;
            ST_POLY:  cmd.op = OP_POLY;
            ST_FIN:   cmd.op = OP_FIN;
            ST_B1:    cmd.op = OP_BLEND1;
            ST_B2:    cmd.op = OP_BLEND2;
            ST_B3:    cmd.op = OP_BLEND3;
            ST_ACC:   cmd.op = OP_ACCUM;
            ST_SCALE: cmd.op = OP_SCALE;
            ST_BIAS:  cmd.op = OP_BIAS;
            ST_HOLD:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    cmd.op         = OP_OUT;
                    out_valid_next = 1'b1;
                end
            end
            default:  cmd.op = OP_NONE;
        endcase
    end

    assign in_stall  = (state_reg != ST_IDLE);
    assign out_valid = out_valid_reg;

    // Hold control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            oct_reg       <= '0;
            corner_reg    <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            oct_reg       <= oct_next;
            corner_reg    <= corner_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

[hw/rtl/ovnh_dp.sv]
// ============================================================================
// ovnh_dp
// Datapath: coordinate scaling, shared lattice hash unit, cosine blend,
// octave accumulation and final height scaling.
// ============================================================================
module ovnh_dp
    import ovnh_pkg::*;
#(
    parameter int COS_STEPS  = 256,
    parameter int COORD_BITS = 16
)
(
    input  logic                         clk,
    input  dp_cmd_t                      cmd,
    input  logic signed [COORD_BITS-1:0] coord_x,
    input  logic signed [COORD_BITS-1:0] coord_z,
    input  logic [31:0]                  seed,
    input  logic [9:0]                   height_gain,
    input  logic signed [10:0]           height_offset,
    input  logic [15:0]                  roughness_q16,
    input  logic [23:0]                  inv_smoothness_q24,
    output logic signed [23:0]           height
);

    localparam int TB = $clog2(COS_STEPS);
    localparam int MW = 56;
    localparam int PW = COORD_BITS + 24;

    // Cosine weight table, built at elaboration
    logic [16:0] wtab [COS_STEPS];
    for (genvar i = 0; i < COS_STEPS; i++)
    begin : g_tab
        localparam logic [63:0] THETA = ANGLE_Q28 * i / COS_STEPS;
        localparam logic [16:0] WVAL  = cos_weight(THETA);
        assign wtab[i] = WVAL;
    end

    logic [MW-1:0]        magx_reg, magz_reg;
    logic                 negx_reg, negz_reg;
    logic [31:0]          ix_reg, iz_reg;
    logic [16:0]          wx_reg, wz_reg;
    logic [31:0]          hn_reg, sq_reg, pp_reg;
    logic signed [17:0]   corner_reg [4];
    logic signed [17:0]   r1_reg, r2_reg, r3_reg;
    logic signed [23:0]   sum_reg;
    logic [16:0]          amp_reg;
    logic signed [31:0]   t_reg;
    logic signed [23:0]   h_reg, height_reg;

    logic [COORD_BITS-1:0] absx, absz;
    logic [PW-1:0]         prodx, prodz;
    logic [31:0]           n_sum, n_mix, q;
    logic [31:0]           ixc, izc;
    logic signed [17:0]    blend_a, blend_b, blend_r;
    logic [16:0]           blend_w;
    logic signed [18:0]    diff;
    logic signed [36:0]    bprod;
    logic signed [35:0]    aprod;
    logic [32:0]           rprod;
    logic signed [39:0]    sprod;
    logic signed [43:0]    hacc;
    logic signed [35:0]    hsh;
    logic signed [23:0]    hsat;

    // Magnitudes of the coordinates times the coordinate scale
    assign absx  = coord_x[COORD_BITS-1] ? COORD_BITS'(-coord_x) : coord_x;
    assign absz  = coord_z[COORD_BITS-1] ? COORD_BITS'(-coord_z) : coord_z;
    assign prodx = PW'(absx) * PW'(inv_smoothness_q24);
    assign prodz = PW'(absz) * PW'(inv_smoothness_q24);

    // Lattice index of the current corner and the first hash mixing step
    assign ixc   = ix_reg + 32'(cmd.corner[0]);
    assign izc   = iz_reg + 32'(cmd.corner[1]);
    assign n_sum = ixc + (izc << 6) + seed;
    assign n_mix = {{13{n_sum[31]}}, n_sum[31:13]} ^ n_sum;
    assign q     = 32'(hn_reg * pp_reg) + HASH_ADD_C;

    // Blend operands
    always_comb
    begin
        case (cmd.op)
            OP_BLEND1:
            begin
                blend_a = corner_reg[0];
                blend_b = corner_reg[1];
                blend_w = wx_reg;
            end
            OP_BLEND2:
            begin
                blend_a = corner_reg[2];
                blend_b = corner_reg[3];
                blend_w = wx_reg;
            end
            default:
            begin
                blend_a = r1_reg;
                blend_b = r2_reg;
                blend_w = wz_reg;
            end
        endcase
    end
    assign diff    = 19'(blend_b) - 19'(blend_a);
    assign bprod   = 37'(diff) * signed'({20'd0, blend_w});
    assign blend_r = 18'(blend_a + 18'(bprod >>> 16));

    // Octave weighting and amplitude decay
    assign aprod = 36'(r3_reg) * signed'({19'd0, amp_reg});
    assign rprod = 33'(amp_reg) * 33'(roughness_q16);

    // Final height
    assign sprod = 40'(sum_reg) * signed'({25'd0, INV_2P1_Q16});
    assign hacc  = 44'(t_reg) * signed'({34'd0, height_gain})
                 + (44'(height_offset) <<< 16);
    assign hsh   = 36'(hacc >>> 8);
    always_comb
    begin
        if (hsh > 36'sd8388607)
            hsat = 24'sh7FFFFF;
        else if (hsh < -36'sd8388608)
            hsat = 24'sh800000;
        else
            hsat = hsh[23:0];
    end

    // Advance the datapath registers as commanded
    always_ff @(posedge clk)
    begin
        case (cmd.op)
            OP_LOAD:
            begin
                magx_reg <= MW'(prodx);
                magz_reg <= MW'(prodz);
                negx_reg <= coord_x[COORD_BITS-1];
                negz_reg <= coord_z[COORD_BITS-1];
                sum_reg  <= '0;
                amp_reg  <= NOISE_ONE;
            end
            OP_SETUP:
            begin
                ix_reg <= negx_reg ? -magx_reg[MW-1:24] : magx_reg[MW-1:24];
                iz_reg <= negz_reg ? -magz_reg[MW-1:24] : magz_reg[MW-1:24];
                wx_reg <= wtab[magx_reg[23 -: TB]];
                wz_reg <= wtab[magz_reg[23 -: TB]];
            end
            OP_MIX:  hn_reg <= n_mix;
            OP_SQ:   sq_reg <= 32'(hn_reg * hn_reg);
            OP_POLY: pp_reg <= 32'(sq_reg * HASH_MUL_A) + HASH_ADD_B;
            OP_FIN:  corner_reg[cmd.corner] <= signed'({1'b0, NOISE_ONE})
                                             - signed'({1'b0, q[30:14]});
            OP_BLEND1: r1_reg <= blend_r;
            OP_BLEND2: r2_reg <= blend_r;
            OP_BLEND3: r3_reg <= blend_r;
            OP_ACCUM:
            begin
                sum_reg  <= sum_reg + 24'(aprod >>> 16);
                amp_reg  <= rprod[32:16];
                magx_reg <= magx_reg << 1;
                magz_reg <= magz_reg << 1;
            end
            OP_SCALE: t_reg <= 32'(sprod >>> 16) + signed'({15'd0, BIAS_Q16});
            OP_BIAS:  h_reg <= hsat;
            OP_OUT:   height_reg <= h_reg;
            default:  ;
        endcase
    end

    assign height = height_reg;

endmodule

[hw/rtl/octave_value_noise_height.sv]
// ============================================================================
// octave_value_noise_height
// Fractal value noise terrain height from a signed grid point.
// ============================================================================
// One height per input word. For each summed octave (octave setting minus
// one, clamped to MAX_OCTAVES minus one) an item runs a setup step, four
// lattice corners of mix, square, polynomial and finish steps each on the
// single shared hash unit, blends along x for both corner pairs and then
// along z, and an accumulate step; the final scaling, saturation and output
// load follow. The next word can be taken in the cycle after the result is
// loaded. A finished height waits in the output register while the next
// word is taken; the next result is held back for as long as the previous
// one is stalled. Configuration is always ready; the user must see that it
// is written only between items, as the block itself does not enforce this.
module octave_value_noise_height
    import ovnh_pkg::*;
#(
    parameter int MAX_OCTAVES = 8,
    parameter int COS_STEPS   = 256,
    parameter int COORD_BITS  = 16
)
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    output logic                         in_stall,
    input  logic signed [COORD_BITS-1:0] coord_x,
    input  logic signed [COORD_BITS-1:0] coord_z,
    output logic                         out_valid,
    input  logic                         out_stall,
    output logic signed [23:0]           height,
    input  logic                         cfg_valid,
    output logic                         cfg_ready,
    input  logic [2:0]                   cfg_index,
    input  logic [31:0]                  cfg_data
);

    logic [31:0]        seed_reg;
    logic [9:0]         gain_reg;
    logic signed [10:0] offset_reg;
    logic [3:0]         octaves_reg;
    logic [15:0]        rough_reg;
    logic [23:0]        inv_smth_reg;
    dp_cmd_t            cmd;

    assign cfg_ready = 1'b1;

    // Register file: take a word at its index, drop unknown indexes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seed_reg     <= SEED_RST;
            gain_reg     <= GAIN_RST;
            offset_reg   <= OFFSET_RST;
            octaves_reg  <= OCTAVES_RST;
            rough_reg    <= ROUGH_RST;
            inv_smth_reg <= INV_SMTH_RST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                REG_SEED:     seed_reg     <= cfg_data;
                REG_GAIN:     gain_reg     <= cfg_data[9:0];
                REG_OFFSET:   offset_reg   <= cfg_data[10:0];
                REG_OCTAVES:  octaves_reg  <= cfg_data[3:0];
                REG_ROUGH:    rough_reg    <= cfg_data[15:0];
                REG_INV_SMTH: inv_smth_reg <= cfg_data[23:0];
                default:      ;
            endcase
        end
    end

    ovnh_ctrl #(
        .MAX_OCTAVES (MAX_OCTAVES)
    ) u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .octave_count (octaves_reg),
        .cmd          (cmd)
    );

    ovnh_dp #(
        .COS_STEPS  (COS_STEPS),
        .COORD_BITS (COORD_BITS)
    ) u_dp (
        .clk                (clk),
        .cmd                (cmd),
        .coord_x            (coord_x),
        .coord_z            (coord_z),
        .seed               (seed_reg),
        .height_gain        (gain_reg),
        .height_offset      (offset_reg),
        .roughness_q16      (rough_reg),
        .inv_smoothness_q24 (inv_smth_reg),
        .height             (height)
    );

endmodule
